@@ sv/pcd_pkg.sv @@
package pcd_pkg;

  // Fixed sizes of the block.
  localparam int MAX_CHANNELS = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS + 1);
  localparam int COUNT_W      = 19;
  localparam int DIV_W        = 5;
  localparam int OFS_W        = 4;
  localparam int REM_W        = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 5;
  localparam int STEP_W       = $clog2(COUNT_W);

  localparam logic [COUNT_W-1:0] WRAP_LIMIT = COUNT_W'(360360);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_USED = 3'd6;

  // Which of the three gates the shared remainder unit is working on.
  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_OUT
  } pcd_state_t;

  // A divider of zero acts as one; anything above sixteen saturates.
  function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] d);
    logic [DIV_W-1:0] r;
    r = d;
    if (d == '0) r = DIV_W'(1);
    else if (d > DIV_W'(16)) r = DIV_W'(16);
    return r;
  endfunction

  // Active channel count limited to 1..MAX_CHANNELS.
  function automatic logic [CH_W-1:0] clamp_ch(input logic [CFG_DATA_W-1:0] n);
    logic [CH_W-1:0] r;
    r = CH_W'(n);
    if (n == '0) r = CH_W'(1);
    else if (n > CFG_DATA_W'(MAX_CHANNELS)) r = CH_W'(MAX_CHANNELS);
    return r;
  endfunction

endpackage

@@ sv/pcd_rem_unit.sv @@
module pcd_rem_unit
  import pcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COUNT_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [REM_W-1:0]   remainder
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] shift;
  logic [REM_W-1:0]   rem;
  logic [DIV_W-1:0]   div;
  logic [DIV_W-1:0]   trial;
  logic [DIV_W-1:0]   trial_sub;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial     = {rem, shift[COUNT_W-1]};
    trial_sub = trial - div;
  end

  // Control of the bit-serial remainder loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(COUNT_W - 1);
      end else if (busy) begin
        if (step == '0) busy <= 1'b0;
        else step <= step - STEP_W'(1);
      end
    end
  end

  // Datapath registers of the remainder loop.
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
      div   <= divisor;
    end else if (busy) begin
      shift <= {shift[COUNT_W-2:0], 1'b0};
      if (trial >= div) rem <= trial_sub[REM_W-1:0];
      else rem <= trial[REM_W-1:0];
    end
  end

  assign remainder = rem;

endmodule

@@ sv/phased_clock_divider_poly_chain.sv @@
// Phased clock divider with a chain of delayed channels.
// Input stream: one item per sample tick; s_tdata holds reset_level in bit 0
// and the sixteen channel clock levels above it. Each accepted item gives
// exactly one result on the output stream: three gate masks, their XOR,
// downbeat and offbeat flags.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// dividers, offsets and active channel count; cfg_ready is always high.
// Each accepted item's beat count is reduced by each of the three dividers
// in turn on one shared restoring remainder unit, one dividend bit per cycle,
// so the three 19-bit reductions make up most of the work for an item.
// s_tready is high only while the sequencer is idle, so a new item is not
// accepted until the previous one has been written to the output register.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already accepted and worked on, and that item then
// waits for the register to free before it is written.
// Reset clears the beat count, the downbeat mask, all stored channel gates
// and prior clock levels, and restores dividers to 1, offsets to 0 and the
// channel count to 1.
module phased_clock_divider_poly_chain
  import pcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Fields from bit 0: reset_level[0], clock_levels[16:1], zero pad.
  input  logic [IN_DATA_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Fields from bit 0: gates_a[15:0], gates_b[31:16], gates_c[47:32],
  // parity_gates[63:48], downbeat[64], offbeats[65], zero pad.
  output logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [DIV_W-1:0]      divider_a, divider_b, divider_c;
  logic [OFS_W-1:0]      offset_a, offset_b, offset_c;
  logic [CFG_DATA_W-1:0] channels_used;

  // Block state.
  logic [COUNT_W-1:0]      beat_count;
  logic                    downbeat_mask;
  logic [MAX_CHANNELS-1:0] prior_clock_levels;
  logic [2:0]              channel_gates [MAX_CHANNELS];

  // Sequencer.
  pcd_state_t state, state_next;
  logic [1:0] sel;
  logic [2:0] hits;
  logic       lvl0;

  // Item fields and derived values.
  logic                    in_reset_level;
  logic [MAX_CHANNELS-1:0] in_clock_levels;
  logic [CH_W-1:0]         n_active;
  logic                    in_accept;
  logic                    rise0;
  logic [COUNT_W:0]        count_inc;
  logic [COUNT_W-1:0]      count_next;

  // Shared remainder unit.
  logic               rem_start;
  logic               rem_done;
  logic [REM_W-1:0]   rem_value;
  logic [DIV_W-1:0]   cur_divider;
  logic [OFS_W-1:0]   cur_offset;

  // Result assembly.
  logic [2:0]              gate0;
  logic [MAX_CHANNELS-1:0] ga, gb, gc, gx;
  logic                    out_load;

  assign in_reset_level  = s_tdata[0];
  assign in_clock_levels = s_tdata[MAX_CHANNELS:1];
  assign n_active        = clamp_ch(channels_used);
  assign s_tready        = (state == ST_IDLE);
  assign in_accept       = s_tvalid && s_tready;
  assign cfg_ready       = 1'b1;

  // Master count: advance on a channel 0 rising edge and wrap past the limit.
  always_comb begin
    rise0      = in_clock_levels[0] && !prior_clock_levels[0];
    count_inc  = {1'b0, beat_count} + (COUNT_W+1)'(1);
    count_next = count_inc[COUNT_W-1:0];
    if (count_next > WRAP_LIMIT) count_next = '0;
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_a     <= DIV_W'(1);
      divider_b     <= DIV_W'(1);
      divider_c     <= DIV_W'(1);
      offset_a      <= '0;
      offset_b      <= '0;
      offset_c      <= '0;
      channels_used <= CFG_DATA_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIVIDER_A:     divider_a     <= cfg_data;
        REG_DIVIDER_B:     divider_b     <= cfg_data;
        REG_DIVIDER_C:     divider_c     <= cfg_data;
        REG_OFFSET_A:      offset_a      <= cfg_data[OFS_W-1:0];
        REG_OFFSET_B:      offset_b      <= cfg_data[OFS_W-1:0];
        REG_OFFSET_C:      offset_c      <= cfg_data[OFS_W-1:0];
        REG_CHANNELS_USED: channels_used <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the divider and offset for the gate now being reduced.
  always_comb begin
    case (sel)
      SEL_A: begin
        cur_divider = clamp_div(divider_a);
        cur_offset  = offset_a;
      end
      SEL_B: begin
        cur_divider = clamp_div(divider_b);
        cur_offset  = offset_b;
      end
      default: begin
        cur_divider = clamp_div(divider_c);
        cur_offset  = offset_c;
      end
    endcase
  end

  pcd_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (beat_count),
    .divisor   (cur_divider),
    .done      (rem_done),
    .remainder (rem_value)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    rem_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_START;
      end
      ST_START: begin
        rem_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (rem_done) state_next = (sel == SEL_C) ? ST_OUT : ST_START;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Gate selector and remainder comparisons.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel  <= SEL_A;
      hits <= '0;
    end else if (in_accept) begin
      sel  <= SEL_A;
      hits <= '0;
    end else if (state == ST_WAIT && rem_done) begin
      hits[sel] <= ({1'b0, rem_value} == {1'b0, cur_offset});
      if (sel != SEL_C) sel <= sel + 2'd1;
    end
  end

  // On acceptance: chain copy, edge tracking, count and mask update; channel 0 gates are stored on output load.
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_count         <= '0;
      downbeat_mask      <= 1'b0;
      prior_clock_levels <= '0;
      lvl0               <= 1'b0;
      for (int p = 0; p < MAX_CHANNELS; p++) channel_gates[p] <= '0;
    end else begin
      if (in_accept) begin
        lvl0                  <= in_clock_levels[0];
        prior_clock_levels[0] <= in_clock_levels[0];
        for (int p = 1; p < MAX_CHANNELS; p++) begin
          if (CH_W'(p) < n_active) begin
            prior_clock_levels[p] <= in_clock_levels[p];
            if (in_clock_levels[p] && !prior_clock_levels[p])
              channel_gates[p] <= channel_gates[p-1];
          end
        end
        if (in_reset_level) begin
          beat_count    <= '0;
          downbeat_mask <= 1'b1;
        end else if (rise0) begin
          beat_count    <= count_next;
          downbeat_mask <= 1'b0;
        end
      end
      if (out_load) channel_gates[0] <= gate0;
    end
  end

  // Channel 0 gates and the masked per-channel outputs.
  always_comb begin
    gate0 = hits & {3{lvl0}};
    for (int p = 0; p < MAX_CHANNELS; p++) begin
      logic [2:0] g;
      g = (p == 0) ? gate0 : channel_gates[p];
      if (CH_W'(p) >= n_active) g = '0;
      ga[p] = g[0];
      gb[p] = g[1];
      gc[p] = g[2];
      gx[p] = g[0] ^ g[1] ^ g[2];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, lvl0 && !downbeat_mask, lvl0 && downbeat_mask, gx, gc, gb, ga};
    end
  end

endmodule
